// ----- sv/sh24_pkg.sv -----
package sh24_pkg;

   // SipHash initialization constants
   localparam logic [63:0] SipC0 = 64'h736f6d6570736575;
   localparam logic [63:0] SipC1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SipC2 = 64'h6c7967656e657261;
   localparam logic [63:0] SipC3 = 64'h7465646279746573;

   // finalization mark xored into v2
   localparam logic [63:0] FinMark = 64'h00000000000000ff;

   // bytes per full word, for the running length
   localparam logic [7:0] WordBytes = 8'd8;

   localparam int WordWidth = 64;
   localparam int TailWidth = 3;
   localparam int CsrIndexWidth = 1;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] RegKeyLow  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] RegKeyHigh = 1'b1;

   // four lanes v0..v3
   typedef logic [3:0][WordWidth-1:0] lanes_type;

   // one input item
   typedef struct packed {
      logic [WordWidth-1:0] message_word;
      logic [TailWidth-1:0] tail_bytes;
      logic                 final_item;
   } item_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

   // one SipRound
   function automatic lanes_type sip_round(input lanes_type v);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b;
      c = c + d;
      b = rotl(b, 13);
      d = rotl(d, 16);
      b = b ^ a;
      d = d ^ c;
      a = rotl(a, 32);
      c = c + b;
      a = a + d;
      b = rotl(b, 17);
      d = rotl(d, 21);
      b = b ^ c;
      d = d ^ a;
      c = rotl(c, 32);
      sip_round = {d, c, b, a};
   endfunction

   // two rounds back to back
   function automatic lanes_type sip_double(input lanes_type v);
      sip_double = sip_round(sip_round(v));
   endfunction

   // compression of one 64-bit word: v3 ^= m, two rounds, v0 ^= m
   function automatic lanes_type sip_absorb(input lanes_type v, input logic [63:0] m);
      lanes_type t;
      t = v;
      t[3] = t[3] ^ m;
      t = sip_double(t);
      t[0] = t[0] ^ m;
      sip_absorb = t;
   endfunction

endpackage

// ----- sv/sh24_compress.sv -----
module sh24_compress (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           key_low,
   input  logic [63:0]           key_high,
   input  logic                  item_valid,
   input  sh24_pkg::item_type    item,
   output logic                  item_ready,
   output logic                  fin_valid,
   output sh24_pkg::lanes_type   fin_lanes,
   input  logic                  fin_ready
);

   sh24_pkg::lanes_type lanes_ff;
   sh24_pkg::lanes_type lanes_in;
   logic [7:0]          len_ff;
   logic [7:0]          len_in;
   logic                open_ff;
   logic                open_in;

   sh24_pkg::lanes_type base_lanes;
   sh24_pkg::lanes_type absorbed;
   logic [7:0]          base_len;
   logic [7:0]          tail_len;
   logic [63:0]         pad_word;
   logic [63:0]         msg;
   logic                fire;

   // a final item needs room in the finalization stage
   assign item_ready = !item.final_item || fin_ready;
   assign fire       = item_valid && item_ready;
   assign fin_valid  = item_valid && item.final_item;

   // starting lanes: key load on a new message
   always_comb begin
      if (open_ff) begin
         base_lanes = lanes_ff;
         base_len   = len_ff;
      end else begin
         base_lanes[0] = key_low ^ sh24_pkg::SipC0;
         base_lanes[1] = key_high ^ sh24_pkg::SipC1;
         base_lanes[2] = key_low ^ sh24_pkg::SipC2;
         base_lanes[3] = key_high ^ sh24_pkg::SipC3;
         base_len      = '0;
      end
   end

   // tail padding: keep low bytes, length byte on top
   always_comb begin
      tail_len = base_len + {5'd0, item.tail_bytes};
      for (int i = 0; i < 8; i++) begin
         pad_word[8*i +: 8] = (i < int'(item.tail_bytes)) ? item.message_word[8*i +: 8] : 8'd0;
      end
      pad_word[63:56] = tail_len;
      msg = item.final_item ? pad_word : item.message_word;
   end

   assign absorbed = sh24_pkg::sip_absorb(base_lanes, msg);

   // finalization input: v2 ^= 0xff
   always_comb begin
      fin_lanes    = absorbed;
      fin_lanes[2] = absorbed[2] ^ sh24_pkg::FinMark;
   end

   // state update
   always_comb begin
      lanes_in = lanes_ff;
      len_in   = len_ff;
      open_in  = open_ff;
      if (fire) begin
         lanes_in = absorbed;
         if (item.final_item) begin
            len_in  = tail_len;
            open_in = 1'b0;
         end else begin
            len_in  = base_len + sh24_pkg::WordBytes;
            open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= '0;
         len_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         lanes_ff <= lanes_in;
         len_ff   <= len_in;
         open_ff  <= open_in;
      end
   end

endmodule

// ----- sv/sh24_final.sv -----
module sh24_final (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  sh24_pkg::lanes_type   up_lanes,
   output logic                  up_ready,
   output logic                  dn_valid,
   output sh24_pkg::lanes_type   dn_lanes,
   input  logic                  dn_ready
);

   logic                valid_ff;
   logic                valid_in;
   sh24_pkg::lanes_type lanes_ff;

   // stage takes a beat when empty or draining
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // two finalization rounds after the stage register
   assign dn_valid = valid_ff;
   assign dn_lanes = sh24_pkg::sip_double(lanes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         lanes_ff <= up_lanes;
      end
   end

endmodule

// ----- sv/siphash_2_4_engine.sv -----
// Channel   Dir  Ports                              Content
// req       in   req_tvalid/tready/tdata/tlast      message word, tail byte count, last word
// rsp       out  rsp_tvalid/tready/tdata            64-bit hash
// csr       in   csr_wen/csr_index/csr_wdata        key_low (0), key_high (1)
//
// A request beat is taken every cycle unless a final word in the input register waits
// for room in finalization. Each word is compressed combinationally from its input
// register; the lane registers close the loop between words. The hash passes from the
// input register through two finalization stages of two rounds each, then the output
// register. Synchronous reset clears all valid flags and the message state. A stall on
// rsp backs up the finalization stages; non-final words flow until a final word is held.
module siphash_2_4_engine (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] message_word, [66:64] tail_bytes, rest zero
   input  logic        req_tlast,   // final_item
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   // configuration
   input  logic                               csr_wen,
   input  logic [sh24_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [63:0]                        csr_wdata
);

   logic [63:0]         key_low_ff;
   logic [63:0]         key_high_ff;

   logic                in_valid_ff;
   logic                in_valid_in;
   sh24_pkg::item_type  in_item_ff;
   logic                item_ready;

   logic                f1_up_valid;
   sh24_pkg::lanes_type f1_up_lanes;
   logic                f1_up_ready;
   logic                f2_up_valid;
   sh24_pkg::lanes_type f2_up_lanes;
   logic                f2_up_ready;
   logic                f2_dn_valid;
   sh24_pkg::lanes_type f2_dn_lanes;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [63:0]         rsp_data_ff;
   logic                rsp_up_ready;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            sh24_pkg::RegKeyLow:  key_low_ff  <= csr_wdata;
            sh24_pkg::RegKeyHigh: key_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   assign req_tready  = !in_valid_ff || item_ready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.message_word <= req_tdata[63:0];
         in_item_ff.tail_bytes   <= req_tdata[66:64];
         in_item_ff.final_item   <= req_tlast;
      end
   end

   // word compression and message state
   sh24_compress u_compress (
      .clock      (clock),
      .reset      (reset),
      .key_low    (key_low_ff),
      .key_high   (key_high_ff),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .item_ready (item_ready),
      .fin_valid  (f1_up_valid),
      .fin_lanes  (f1_up_lanes),
      .fin_ready  (f1_up_ready)
   );

   // finalization rounds 1-2
   sh24_final u_final_a (
      .clock    (clock),
      .reset    (reset),
      .up_valid (f1_up_valid),
      .up_lanes (f1_up_lanes),
      .up_ready (f1_up_ready),
      .dn_valid (f2_up_valid),
      .dn_lanes (f2_up_lanes),
      .dn_ready (f2_up_ready)
   );

   // finalization rounds 3-4
   sh24_final u_final_b (
      .clock    (clock),
      .reset    (reset),
      .up_valid (f2_up_valid),
      .up_lanes (f2_up_lanes),
      .up_ready (f2_up_ready),
      .dn_valid (f2_dn_valid),
      .dn_lanes (f2_dn_lanes),
      .dn_ready (rsp_up_ready)
   );

   // output register: hash is the xor of all lanes
   assign rsp_up_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = rsp_up_ready ? f2_dn_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_up_ready && f2_dn_valid) begin
         rsp_data_ff <= f2_dn_lanes[0] ^ f2_dn_lanes[1] ^ f2_dn_lanes[2] ^ f2_dn_lanes[3];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a final word taken by the compressor lands in the first finalization stage
   a_final_enters: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && item_ready && in_item_ff.final_item) |=> f2_up_valid)
      else $error("final word lost before finalization");

   // request side only backs up behind a held word
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_item_ff.final_item && !f1_up_ready))
      else $error("request stalled without a blocked final word");

   // a blocked last stage keeps its result for the output register
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (f2_dn_valid && !rsp_up_ready) |=> (f2_dn_valid && rsp_valid_ff))
      else $error("finalization result dropped under stall");
`endif

endmodule
